[sv/mwk_pkg.sv]
// ----------------------------------------------------------------------------
// mwk_pkg
// Shared widths, codes and types of the Markov usage-model walker.
// ----------------------------------------------------------------------------
package mwk_pkg;

  localparam int NUM_STATES  = 16;
  localparam int MAX_EDGES   = 8;
  localparam int WEIGHT_BITS = 16;
  localparam int COUNT_BITS  = 32;

  localparam int SW    = $clog2(NUM_STATES);
  localparam int EW    = $clog2(MAX_EDGES);
  localparam int KW    = SW + EW;
  localparam int TW    = WEIGHT_BITS + EW;
  localparam int RND_W = 7;
  localparam int PW    = TW + RND_W;
  localparam int STIM_W = 8;
  localparam int EDGE_W = STIM_W + SW + WEIGHT_BITS;
  localparam int MULT   = 97;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_BEGIN = 2'd1;
  localparam logic [1:0] FN_STEP  = 2'd2;
  localparam logic [1:0] FN_READ  = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_ENDED = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  localparam logic CFG_START_STATE = 1'b0;
  localparam logic CFG_END_STATE   = 1'b1;

  typedef struct packed {
    logic          vis_set;
    logic [KW-1:0] vis_idx;
    logic          n_we;
    logic [SW-1:0] n_idx;
    logic [EW:0]   n_val;
  } cov_upd_t;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

[sv/markov_usage_model_walker_core.sv]
// ----------------------------------------------------------------------------
// markov_usage_model_walker_core
// Markov usage-model walker: edge table, roulette step, visit counters.
// A load, or a step that ends at once (walk ended, no edges), passes EXEC, WAIT
// and FIN; begin adds BUMP_WR and read adds RDATA before WAIT; a step over edges
// adds SUM, MUL, SCAN, BUMP_RD and BUMP_WR, with two pipelined passes over the
// edge memory read port (weight sum, then roulette scan, which stops at the chosen
// edge). One item at a time; a new item is taken once the result is registered.
// Reset (rst_n, synchronous, active low) clears counters and visited marks
// through valid bits at once; the edge table is undefined until loaded.
// ----------------------------------------------------------------------------
module markov_usage_model_walker_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [3:0]                  in_state_index,
  input  logic [2:0]                  in_edge_slot,
  input  logic [15:0]                 in_edge_weight,
  input  logic [3:0]                  in_edge_target,
  input  logic [7:0]                  in_edge_stimulus,
  input  logic [3:0]                  in_edge_total,
  input  logic [6:0]                  in_random_value,
  input  logic                        in_read_edge,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_next_state,
  output logic [7:0]                  out_stimulus,
  output logic                        out_walk_done,
  output logic                        out_all_edges_visited,
  output logic [31:0]                 out_count_value,
  output logic [1:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [3:0]                  cfg_data
);
  import mwk_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_SUM, ST_MUL, ST_SCAN, ST_BUMP_RD, ST_BUMP_WR,
    ST_RDATA, ST_WAIT, ST_FIN
  } st_t;

  st_t st_r, st_nxt;

  logic [1:0]             fn_r;
  logic [SW-1:0]          sidx_r, start_r, end_r, cur_r, cur_nxt;
  logic [EW-1:0]          slot_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [SW-1:0]          tgt_r;
  logic [STIM_W-1:0]      stim_r;
  logic [3:0]             etot_r;
  logic [RND_W-1:0]       rnd_r;
  logic                   rde_r;

  logic [EW:0]            idx_r, idx_nxt;
  logic                   pend_r, pend_nxt;
  logic [EW-1:0]          didx_r, didx_nxt;
  logic [TW-1:0]          total_r, total_nxt, run_r, run_nxt, run_sum;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic                   cmp;
  logic [EW-1:0]          pick_r, pick_nxt;
  logic [SW-1:0]          ptgt_r, ptgt_nxt;
  logic [STIM_W-1:0]      pstim_r, pstim_nxt;
  logic [KW-1:0]          ekey_r, ekey_nxt;
  logic                   ebump_r, ebump_nxt;
  logic [1:0]             sts_r, sts_nxt;
  logic [STIM_W-1:0]      sres_r, sres_nxt;
  logic [31:0]            cres_r, cres_nxt;
  logic [NUM_STATES-1:0]  svld_r, svld_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [3:0]             o_state_r;
  logic [7:0]             o_stim_r;
  logic                   o_done_r, o_all_r;
  logic [31:0]            o_cnt_r;
  logic [1:0]             o_sts_r;
  logic                   o_load;

  logic                   ed_we;
  logic [KW-1:0]          ed_waddr, ed_raddr;
  logic [EDGE_W-1:0]      ed_wdata, ed_rdata;
  logic                   ec_we;
  logic [KW-1:0]          ec_raddr;
  logic [COUNT_BITS-1:0]  ec_wdata, ec_rdata;
  logic                   sc_we;
  logic [SW-1:0]          sc_raddr;
  logic [COUNT_BITS-1:0]  sc_wdata, sc_rdata, cnt_sel;

  cov_upd_t               upd;
  logic [EW:0]            n_cur;
  logic [KW-1:0]          vis_addr;
  logic                   vis_bit, all_vis;

  logic [WEIGHT_BITS-1:0] rd_w;
  logic [SW-1:0]          rd_tgt;
  logic [STIM_W-1:0]      rd_stim;

  mwk_ram #(.WIDTH(EDGE_W), .DEPTH(NUM_STATES * MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
    .raddr(ed_raddr), .rdata(ed_rdata)
  );

  mwk_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_STATES * MAX_EDGES)) u_ecnt_ram (
    .clk(clk), .we(ec_we), .waddr(ekey_r), .wdata(ec_wdata),
    .raddr(ec_raddr), .rdata(ec_rdata)
  );

  mwk_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_STATES)) u_scnt_ram (
    .clk(clk), .we(sc_we), .waddr(cur_r), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rdata)
  );

  mwk_cover u_cover (
    .clk(clk), .rst_n(rst_n), .upd_i(upd), .n_addr_i(cur_r), .n_o(n_cur),
    .vis_addr_i(vis_addr), .vis_o(vis_bit), .all_vis_o(all_vis)
  );

  assign {rd_stim, rd_tgt, rd_w} = ed_rdata;
  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign vis_addr  = (st_r == ST_RDATA) ? {sidx_r, slot_r} : ekey_r;
  assign run_sum   = run_r + TW'(rd_w);
  assign cmp       = prod_r <= PW'(run_sum) * PW'(MULT);
  assign o_load    = (st_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    didx_nxt  = didx_r;
    total_nxt = total_r;
    run_nxt   = run_r;
    prod_nxt  = prod_r;
    pick_nxt  = pick_r;
    ptgt_nxt  = ptgt_r;
    pstim_nxt = pstim_r;
    ekey_nxt  = ekey_r;
    ebump_nxt = ebump_r;
    sts_nxt   = sts_r;
    sres_nxt  = sres_r;
    cres_nxt  = cres_r;
    svld_nxt  = svld_r;
    ed_we     = 1'b0;
    ed_waddr  = {sidx_r, slot_r};
    ed_wdata  = {stim_r, tgt_r, w_r};
    ed_raddr  = {cur_r, idx_r[EW-1:0]};
    ec_we     = 1'b0;
    ec_raddr  = {cur_r, pick_r};
    ec_wdata  = bump(vis_bit ? ec_rdata : '0);
    sc_we     = 1'b0;
    sc_raddr  = sidx_r;
    sc_wdata  = bump(svld_r[cur_r] ? sc_rdata : '0);
    cnt_sel   = '0;
    upd       = '0;
    upd.vis_idx = ekey_r;
    upd.n_idx   = sidx_r;
    upd.n_val   = (etot_r > 4'(MAX_EDGES)) ? (EW+1)'(MAX_EDGES) : (EW+1)'(etot_r);
    out_valid_nxt = out_valid_r && out_stall;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        sts_nxt  = STS_OK;
        sres_nxt = '0;
        cres_nxt = '0;
        case (fn_r)
          FN_LOAD: begin
            ed_we      = 1'b1;
            upd.n_we   = 1'b1;
            st_nxt     = ST_WAIT;
          end
          FN_BEGIN: begin
            cur_nxt   = start_r;
            sc_raddr  = start_r;
            ebump_nxt = 1'b0;
            st_nxt    = ST_BUMP_WR;
          end
          FN_STEP: begin
            idx_nxt   = '0;
            total_nxt = '0;
            if (cur_r == end_r) begin
              sts_nxt = STS_ENDED;
              st_nxt  = ST_WAIT;
            end else if (n_cur == '0) begin
              sts_nxt = STS_EMPTY;
              st_nxt  = ST_WAIT;
            end else begin
              st_nxt = ST_SUM;
            end
          end
          FN_READ: begin
            ec_raddr = {sidx_r, slot_r};
            st_nxt   = ST_RDATA;
          end
          default: st_nxt = ST_WAIT;
        endcase
      end
      ST_SUM: begin
        if (idx_r < n_cur) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          total_nxt = total_r + TW'(rd_w);
        end
        if (idx_r == n_cur && pend_r) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = PW'(rnd_r) * PW'(total_r);
        idx_nxt  = '0;
        run_nxt  = '0;
        st_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r < n_cur) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
          didx_nxt = idx_r[EW-1:0];
        end
        if (pend_r) begin
          run_nxt = run_sum;
          if (didx_r == '0 || cmp) begin
            pick_nxt  = didx_r;
            ptgt_nxt  = rd_tgt;
            pstim_nxt = rd_stim;
          end
          if (cmp || {1'b0, didx_r} == n_cur - 1'b1) begin
            st_nxt = ST_BUMP_RD;
          end
        end
      end
      ST_BUMP_RD: begin
        ekey_nxt  = {cur_r, pick_r};
        sc_raddr  = ptgt_r;
        cur_nxt   = ptgt_r;
        ebump_nxt = 1'b1;
        sres_nxt  = pstim_r;
        st_nxt    = ST_BUMP_WR;
      end
      ST_BUMP_WR: begin
        sc_we          = 1'b1;
        svld_nxt[cur_r] = 1'b1;
        if (ebump_r) begin
          ec_we       = 1'b1;
          upd.vis_set = 1'b1;
        end
        st_nxt = ST_WAIT;
      end
      ST_RDATA: begin
        if (rde_r) begin
          cnt_sel = vis_bit ? ec_rdata : '0;
        end else begin
          cnt_sel = svld_r[sidx_r] ? sc_rdata : '0;
        end
        cres_nxt = 32'(cnt_sel);
        st_nxt   = ST_WAIT;
      end
      ST_WAIT: begin
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (o_load) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      start_r     <= '0;
      end_r       <= SW'(15);
      cur_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      ebump_r     <= 1'b0;
      svld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cur_r       <= cur_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      ebump_r     <= ebump_nxt;
      svld_r      <= svld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START_STATE) begin
          start_r <= cfg_data;
        end else begin
          end_r <= cfg_data;
        end
      end
    end
    if (st_r == ST_IDLE && in_valid) begin
      fn_r   <= in_func;
      sidx_r <= in_state_index;
      slot_r <= in_edge_slot;
      w_r    <= in_edge_weight;
      tgt_r  <= in_edge_target;
      stim_r <= in_edge_stimulus;
      etot_r <= in_edge_total;
      rnd_r  <= in_random_value;
      rde_r  <= in_read_edge;
    end
    didx_r  <= didx_nxt;
    total_r <= total_nxt;
    run_r   <= run_nxt;
    prod_r  <= prod_nxt;
    pick_r  <= pick_nxt;
    ptgt_r  <= ptgt_nxt;
    pstim_r <= pstim_nxt;
    ekey_r  <= ekey_nxt;
    sts_r   <= sts_nxt;
    sres_r  <= sres_nxt;
    cres_r  <= cres_nxt;
    if (o_load) begin
      o_state_r <= cur_r;
      o_stim_r  <= sres_r;
      o_done_r  <= (cur_r == end_r);
      o_all_r   <= all_vis;
      o_cnt_r   <= cres_r;
      o_sts_r   <= sts_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_next_state        = o_state_r;
  assign out_stimulus          = o_stim_r;
  assign out_walk_done         = o_done_r;
  assign out_all_edges_visited = o_all_r;
  assign out_count_value       = o_cnt_r;
  assign out_status            = o_sts_r;

`ifndef ASSERT_OFF
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_FIN))
    else $error("result raised outside final state");

  a_no_stim_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status != STS_OK) |-> (out_stimulus == '0))
    else $error("stimulus reported on a step that was not taken");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BUMP_RD) |-> ({1'b0, pick_r} < n_cur))
    else $error("picked edge beyond the state's edge count");
`endif

endmodule

[sv/mwk_ram.sv]
// ----------------------------------------------------------------------------
// mwk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mwk_cover.sv]
// ----------------------------------------------------------------------------
// mwk_cover
// Edge counts per state, edge visited marks and the all-edges-visited flag.
// ----------------------------------------------------------------------------
module mwk_cover (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mwk_pkg::cov_upd_t       upd_i,
  input  logic [mwk_pkg::SW-1:0]  n_addr_i,
  output logic [mwk_pkg::EW:0]    n_o,
  input  logic [mwk_pkg::KW-1:0]  vis_addr_i,
  output logic                    vis_o,
  output logic                    all_vis_o
);
  import mwk_pkg::*;

  logic [NUM_STATES-1:0][MAX_EDGES-1:0] vis_r;
  logic [NUM_STATES-1:0][EW:0]          n_r;
  logic [NUM_STATES-1:0]                ok_r;
  logic [NUM_STATES-1:0]                ok_nxt;

  always_comb begin
    for (int s = 0; s < NUM_STATES; s++) begin
      logic [MAX_EDGES-1:0] used;
      for (int e = 0; e < MAX_EDGES; e++) begin
        used[e] = ((EW+1)'(e) < n_r[s]);
      end
      ok_nxt[s] = &(vis_r[s] | ~used);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0;
      n_r   <= '0;
      ok_r  <= '1;
    end else begin
      if (upd_i.vis_set) begin
        vis_r[upd_i.vis_idx[KW-1:EW]][upd_i.vis_idx[EW-1:0]] <= 1'b1;
      end
      if (upd_i.n_we) begin
        n_r[upd_i.n_idx] <= upd_i.n_val;
      end
      ok_r <= ok_nxt;
    end
  end

  assign n_o       = n_r[n_addr_i];
  assign vis_o     = vis_r[vis_addr_i[KW-1:EW]][vis_addr_i[EW-1:0]];
  assign all_vis_o = &ok_r;

endmodule
